// ===== rtl/core/rational_arithmetic_unit_macros.svh =====
// Assertion helpers used by rau_ctrl
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define RAU_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
    localparam int unsigned WIDTH = 32;
    localparam int unsigned DW = 2 * WIDTH + 2;  // product width, signed
    localparam int unsigned MW = DW - 1;         // magnitude width
    localparam int unsigned CW = $clog2(MW + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;

    // controller commands to datapath
    typedef struct packed {
        logic load;       // latch operands
        logic mul1;       // first product step
        logic mul2;       // second product step
        logic form;       // form num/den magnitudes
        logic gcd_init;   // x=nm, y=dm
        logic div_start;  // start divide of div_n by div_d
        logic [1:0] div_sel;  // 0 x%y, 1 nm/g, 2 dm/g
        logic gcd_step;   // x=y, y=rem
        logic q_num;      // latch quotient to num
        logic q_den;      // latch quotient to den
        logic finish;     // build result
    } cmd_t;

    typedef struct packed {
        logic bad_in;     // zero denominator on input
        logic den_zero;   // formed denominator zero
        logic y_zero;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Channel | Dir | Fields (tdata/tuser, low bit first)
// s_axis  | in  | tdata: op[2:0] a_num[34:3] a_den[65:35] b_num[97:66] b_den[128:98]
// m_axis  | out | tdata: res_num[31:0] res_den[62:32] status[64:63]
// One item at a time; the shared one-bit-per-cycle divider runs Euclid and
// the two reductions. A zero input denominator or a zero formed denominator
// goes straight to the result. Reset rst_n clears the controller, asynchronous.
// A held result keeps s_axis_tready low until m_axis_tready takes it.
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // op, a_num, a_den, b_num, b_den
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata   // res_num, res_den, status
);
    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0] status;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .op(s_axis_tdata[2:0]), .a_num(s_axis_tdata[34:3]),
        .a_den(s_axis_tdata[65:35]), .b_num(s_axis_tdata[97:66]),
        .b_den(s_axis_tdata[128:98]),
        .res_num(res_num), .res_den(res_den), .status(status)
    );

    assign m_axis_tdata = {7'd0, status, res_den, res_num};
endmodule
`default_nettype wire

// ===== rtl/core/rau_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle
module rau_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [rau_pkg::MW-1:0] dividend,
    input  wire logic [rau_pkg::MW-1:0] divisor,
    output logic                        done,
    output logic      [rau_pkg::MW-1:0] quo,
    output logic      [rau_pkg::MW-1:0] rem
);
    logic [rau_pkg::MW-1:0] q_reg, q_next, d_reg, d_next;
    logic [rau_pkg::MW:0]   r_reg, r_next, trial;
    logic [rau_pkg::CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        q_next = q_reg;
        d_next = d_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[rau_pkg::MW-1:0], q_reg[rau_pkg::MW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            d_next = divisor;
            r_next = '0;
            cnt_next = rau_pkg::CW'(rau_pkg::MW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[rau_pkg::MW])
            begin
                r_next = {r_reg[rau_pkg::MW-1:0], q_reg[rau_pkg::MW-1]};
                q_next = {q_reg[rau_pkg::MW-2:0], 1'b0};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[rau_pkg::MW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rau_pkg::CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg[rau_pkg::MW-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/rau_datapath.sv =====
`default_nettype none
module rau_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rau_pkg::cmd_t cmd,
    output rau_pkg::sts_t      sts,
    input  wire logic [2:0]    op,
    input  wire logic [31:0]   a_num,
    input  wire logic [30:0]   a_den,
    input  wire logic [31:0]   b_num,
    input  wire logic [30:0]   b_den,
    output logic [31:0]        res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);
    localparam int unsigned W = rau_pkg::WIDTH;
    localparam int unsigned DW = rau_pkg::DW;
    localparam int unsigned MW = rau_pkg::MW;

    logic [2:0] op_reg;
    logic signed [W-1:0] an_reg, bn_reg;
    logic [W-2:0] ad_reg, bd_reg;
    logic signed [DW-1:0] p1_reg, p2_reg, pd_reg;
    logic neg_reg;
    logic [MW-1:0] nm_reg, dm_reg, x_reg, y_reg;
    logic [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic [1:0] st_reg;

    logic signed [DW-1:0] an_x, bn_x, ad_x, bd_x, num_v, den_v;
    logic [MW-1:0] div_n, div_d, quo, rem;
    logic div_done;
    logic [MW-1:0] lim;

    assign an_x = DW'(an_reg);
    assign bn_x = DW'(bn_reg);
    assign ad_x = DW'($signed({1'b0, ad_reg}));
    assign bd_x = DW'($signed({1'b0, bd_reg}));
    assign lim = MW'(1) << (W - 1);

    always_comb
    begin
        case (op_reg)
            rau_pkg::OP_ADD: num_v = p1_reg + p2_reg;
            rau_pkg::OP_SUB: num_v = p1_reg - p2_reg;
            rau_pkg::OP_NEG: num_v = -p1_reg;
            default:         num_v = p1_reg;
        endcase
        den_v = pd_reg;
    end

    always_comb
    begin
        case (cmd.div_sel)
            2'd0:    begin div_n = x_reg;  div_d = y_reg; end
            2'd1:    begin div_n = nm_reg; div_d = x_reg; end
            default: begin div_n = dm_reg; div_d = x_reg; end
        endcase
    end

    rau_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(div_n), .divisor(div_d),
        .done(div_done), .quo(quo), .rem(rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            an_reg <= a_num[W-1:0];
            bn_reg <= b_num[W-1:0];
            ad_reg <= a_den[W-2:0];
            bd_reg <= b_den[W-2:0];
        end
        if (cmd.mul1)
        begin
            // first product: num term from a
            case (op_reg)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_DIV: p1_reg <= an_x * bd_x;
                rau_pkg::OP_MUL: p1_reg <= an_x * bn_x;
                default:         p1_reg <= an_x;
            endcase
            p2_reg <= bn_x * ad_x;
        end
        if (cmd.mul2)
        begin
            case (op_reg)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL: pd_reg <= ad_x * bd_x;
                rau_pkg::OP_DIV: pd_reg <= ad_x * bn_x;
                default:         pd_reg <= ad_x;
            endcase
        end
        if (cmd.form)
        begin
            neg_reg <= num_v[DW-1] ^ den_v[DW-1];
            nm_reg <= num_v[DW-1] ? MW'(-num_v) : MW'(num_v);
            dm_reg <= den_v[DW-1] ? MW'(-den_v) : MW'(den_v);
        end
        if (cmd.gcd_init)
        begin
            x_reg <= nm_reg;
            y_reg <= dm_reg;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= rem;
        end
        if (cmd.q_num)
            nm_reg <= quo;
        if (cmd.q_den)
            dm_reg <= quo;
        if (cmd.finish)
        begin
            rn_reg <= '0;
            rd_reg <= '0;
            if (sts.bad_in || sts.den_zero)
                st_reg <= rau_pkg::ST_DIV0;
            else if (nm_reg == '0)
            begin
                st_reg <= rau_pkg::ST_OK;
                rd_reg <= 31'd1;
            end
            else if (dm_reg > lim - 1'b1 || nm_reg > (neg_reg ? lim : lim - 1'b1))
                st_reg <= rau_pkg::ST_WIDE;
            else
            begin
                st_reg <= rau_pkg::ST_OK;
                rn_reg <= neg_reg ? 32'(-nm_reg) : 32'(nm_reg);
                rd_reg <= 31'(dm_reg);
            end
        end
    end

    assign sts.bad_in   = (ad_reg == '0) || (op_reg <= rau_pkg::OP_DIV && bd_reg == '0);
    assign sts.den_zero = (pd_reg == '0);
    assign sts.y_zero   = (y_reg == '0);
    assign sts.div_done = div_done;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign status  = st_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rau_ctrl.sv =====
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rau_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_fire,
    input  wire rau_pkg::sts_t sts,
    output rau_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GINIT, S_GTEST, S_GWAIT,
        S_NSTART, S_NWAIT, S_DSTART, S_DWAIT, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic out_valid_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.load = in_fire;
            S_MUL1:   cmd.mul1 = 1'b1;
            S_MUL2:   cmd.mul2 = 1'b1;
            S_FORM:   cmd.form = 1'b1;
            S_GINIT:  cmd.gcd_init = 1'b1;
            S_GTEST:  cmd.div_start = !sts.y_zero;
            S_GWAIT:  cmd.gcd_step = sts.div_done;
            S_NSTART: begin cmd.div_start = 1'b1; cmd.div_sel = 2'd1; end
            S_NWAIT:  begin cmd.div_sel = 2'd1; cmd.q_num = sts.div_done; end
            S_DSTART: begin cmd.div_start = 1'b1; cmd.div_sel = 2'd2; end
            S_DWAIT:  begin cmd.div_sel = 2'd2; cmd.q_den = sts.div_done; end
            S_FIN:    cmd.finish = 1'b1;
            S_OUT:    ;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_fire) state_reg <= S_MUL1;
                S_MUL1:   state_reg <= S_MUL2;
                S_MUL2:   state_reg <= sts.bad_in ? S_FIN : S_FORM;
                S_FORM:   state_reg <= sts.den_zero ? S_FIN : S_GINIT;
                S_GINIT:  state_reg <= S_GTEST;
                S_GTEST:  state_reg <= sts.y_zero ? S_NSTART : S_GWAIT;
                S_GWAIT:  if (sts.div_done) state_reg <= S_GTEST;
                S_NSTART: state_reg <= S_NWAIT;
                S_NWAIT:  if (sts.div_done) state_reg <= S_DSTART;
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT:  if (sts.div_done) state_reg <= S_FIN;
                S_FIN:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (out_fire)
                    begin
                        state_reg <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `RAU_ASSERT_IMP(a_ready_excl, clk, rst_n, out_valid, !in_ready)
    `RAU_ASSERT_NEXT(a_fin_valid, clk, rst_n, cmd.finish, out_valid)
    `RAU_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.mul1, cmd.mul2,
        cmd.form, cmd.finish}))
endmodule
`default_nettype wire
